// ===== rtl/lzwe_pkg.sv =====
// Package: shared types and constants of the hashed-dictionary LZW encoder.
`default_nettype none
package lzwe_pkg;
    localparam int CODE_W  = 16;
    localparam int NEXT_W  = 17;
    localparam int EPOCH_W = 8;
    localparam int SLOT_W  = EPOCH_W + CODE_W;
    localparam int KEY_W   = CODE_W + 8;
    localparam int X_W     = 25;                  // prefix*257 + byte
    localparam logic [NEXT_W-1:0] FIRST_CODE = NEXT_W'(256);
    localparam logic [4:0] MIN_BITS = 5'd9;
    localparam logic [4:0] BITS_CEIL = 5'd16;

    localparam logic [1:0] REG_CODE_BITS = 2'd0;
    localparam logic [1:0] REG_RESET_FULL = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic              final_code;
    } t_out_item;

    typedef struct packed {
        logic            push;
        t_out_item       item;
    } t_oq_push;
endpackage
`default_nettype wire

// ===== rtl/lzwe_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lzwe_hash.sv =====
// Home slot of a (prefix, byte) pair: (prefix*257 + byte) mod HASH_ENTRIES, two stages.
`default_nettype none
module lzwe_hash import lzwe_pkg::*; #(
    parameter int HASH_ENTRIES = 131071
) (
    input  wire logic                            i_clk,
    input  wire logic [CODE_W-1:0]               i_prefix,
    input  wire logic [7:0]                      i_byte,
    output logic      [$clog2(HASH_ENTRIES)-1:0] o_home
);
    localparam int HW = $clog2(HASH_ENTRIES);
    localparam int SH = X_W + HW;                 // reciprocal scale
    localparam int MW = X_W + 2;
    localparam int QW = X_W + 1 - HW;
    localparam longint MREC = (64'd1 << SH) / HASH_ENTRIES + 1;
    localparam logic [X_W-1:0] HMOD = X_W'(HASH_ENTRIES);

    logic [X_W-1:0]    x;
    logic [X_W+MW-1:0] prod;
    logic [X_W-1:0]    r_x;
    logic [QW-1:0]     r_q;
    logic [X_W-1:0]    qh;

    assign x    = ({1'b0, i_prefix, 8'd0} + {9'd0, i_prefix}) + {17'd0, i_byte};
    assign prod = {{MW{1'b0}}, x} * {{X_W{1'b0}}, MW'(MREC)};
    assign qh   = {{(X_W-QW){1'b0}}, r_q} * HMOD;

    always_ff @(posedge i_clk) begin
        r_x    <= x;
        r_q    <= prod[SH +: QW];
        o_home <= HW'(r_x - qh);
    end
endmodule
`default_nettype wire

// ===== rtl/lzwe_oq.sv =====
// Four-item output queue between the encoder core and the result channel.
`default_nettype none
module lzwe_oq import lzwe_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_oq_push  i_push,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item,
    output logic [2:0]     o_count
);
    t_out_item  r_buf [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_count;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 3'd0);
    assign o_item  = r_buf[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (i_push.push) begin
                r_buf[r_wp] <= i_push.item;
                r_wp        <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_count <= r_count + {2'd0, i_push.push} - {2'd0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/lzw_encoder_hashed_dictionary.sv =====
// Top level: LZW encoder with a linear-probing hashed dictionary.
//
//  channel | dir | handshake                | payload
//  in      | in  | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  out     | out | o_out_valid / i_out_ready| o_out_data (t_out_item)
//  cfg     | in  | i_cfg_we                 | i_cfg_idx, i_cfg_wdata
//
// A byte first waits for the hash of its pair; each probe of the hash slot memory is a
// slot read, then an entry read. A miss that inserts probes the slot memory again.
// A stream's first byte needs no lookup. After reset and every 255 dictionary clears,
// a pass over all slots rewrites the slot memory; no item is accepted meanwhile.
// Clearing otherwise bumps an epoch tag kept in every slot.
// Up to four results queue at the output; input stalls when two slots are not free.
`default_nettype none
module lzw_encoder_hashed_dictionary import lzwe_pkg::*; #(
    parameter int DICT_ENTRIES = 65536,
    parameter int HASH_ENTRIES = 131071
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [4:0] i_cfg_wdata
);
    localparam int HW = $clog2(HASH_ENTRIES);
    localparam int DW = $clog2(DICT_ENTRIES);
    localparam int PW = $clog2(HASH_ENTRIES + 1);
    localparam logic [HW-1:0] H_LAST = HW'(HASH_ENTRIES - 1);
    localparam logic [PW-1:0] H_CNT  = PW'(HASH_ENTRIES);
    localparam logic [NEXT_W-1:0] DICT_MAX = NEXT_W'(DICT_ENTRIES);

    localparam logic [3:0] S_SWEEP = 4'd0, S_IDLE = 4'd1, S_H1 = 4'd2, S_H2 = 4'd3,
                           S_H3 = 4'd4, S_LRD = 4'd5, S_LSLOT = 4'd6, S_LENT = 4'd7,
                           S_MISS = 4'd8, S_IRD = 4'd9, S_ICHK = 4'd10, S_FIN = 4'd11;

    logic [3:0]         r_state, n_state;
    logic [4:0]         r_code_bits;
    logic               r_rwf;
    logic [CODE_W-1:0]  r_prefix, n_prefix;
    logic               r_pvalid, n_pvalid;
    logic [7:0]         r_byte, n_byte;
    logic               r_last, n_last;
    logic [NEXT_W-1:0]  r_next, n_next;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic               r_cleared, n_cleared;
    logic [HW-1:0]      r_h, n_h;
    logic [PW-1:0]      r_probe, n_probe;
    logic [CODE_W-1:0]  r_code, n_code;

    logic [HW-1:0]     home, h_next;
    logic [SLOT_W-1:0] slot_rd, slot_wd;
    logic              slot_we, slot_re;
    logic [KEY_W-1:0]  ent_rd;
    logic              ent_we, ent_re;
    logic [4:0]        bits;
    logic [NEXT_W-1:0] limit, lim_raw;
    logic              slot_live, in_acc;
    logic [2:0]        oq_count;
    t_oq_push          push;

    lzwe_hash #(.HASH_ENTRIES(HASH_ENTRIES)) u_hash (
        .i_clk(i_clk), .i_prefix(r_prefix), .i_byte(r_byte), .o_home(home)
    );

    lzwe_ram #(.WIDTH(SLOT_W), .DEPTH(HASH_ENTRIES)) u_slots (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(r_h), .i_wdata(slot_wd),
        .i_re(slot_re), .i_raddr(r_h), .o_rdata(slot_rd)
    );

    lzwe_ram #(.WIDTH(KEY_W), .DEPTH(DICT_ENTRIES)) u_entries (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(r_next[DW-1:0]),
        .i_wdata({r_prefix, r_byte}), .i_re(ent_re),
        .i_raddr(slot_rd[DW-1:0]), .o_rdata(ent_rd)
    );

    lzwe_oq u_oq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_valid(o_out_valid),
        .i_ready(i_out_ready), .o_item(o_out_data), .o_count(oq_count)
    );

    always_comb begin
        bits = r_code_bits;
        if (bits < MIN_BITS) bits = MIN_BITS;
        if (bits > BITS_CEIL) bits = BITS_CEIL;
        lim_raw = NEXT_W'(1) << bits;
        limit   = (lim_raw > DICT_MAX) ? DICT_MAX : lim_raw;
    end

    assign h_next     = (r_h == H_LAST) ? '0 : r_h + HW'(1);
    assign slot_live  = (slot_rd[SLOT_W-1 -: EPOCH_W] == r_epoch);
    assign o_in_ready = (r_state == S_IDLE) && (r_epoch != '0) && (oq_count <= 3'd2);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_prefix  = r_prefix;
        n_pvalid  = r_pvalid;
        n_byte    = r_byte;
        n_last    = r_last;
        n_next    = r_next;
        n_epoch   = r_epoch;
        n_cleared = r_cleared;
        n_h       = r_h;
        n_probe   = r_probe;
        n_code    = r_code;
        slot_we   = 1'b0;
        slot_re   = 1'b0;
        slot_wd   = '0;
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        push      = '0;
        case (r_state)
            S_SWEEP: begin
                slot_we = 1'b1;
                n_h     = h_next;
                if (r_h == H_LAST) begin
                    n_epoch = EPOCH_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_epoch == '0) begin
                    n_h     = '0;
                    n_state = S_SWEEP;
                end else if (in_acc) begin
                    n_byte = i_in_data.data_byte;
                    n_last = i_in_data.end_of_stream;
                    if (!r_pvalid) begin
                        n_prefix = {8'd0, i_in_data.data_byte};
                        n_pvalid = 1'b1;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_H1;
                    end
                end
            end
            S_H1: n_state = S_H2;
            S_H2: n_state = S_H3;
            S_H3: begin
                n_h     = home;
                n_probe = '0;
                n_state = S_LRD;
            end
            S_LRD: begin
                slot_re = 1'b1;
                n_state = S_LSLOT;
            end
            S_LSLOT: begin
                if (!slot_live) begin
                    n_state = S_MISS;
                end else begin
                    ent_re  = 1'b1;
                    n_code  = slot_rd[CODE_W-1:0];
                    n_state = S_LENT;
                end
            end
            S_LENT: begin
                if (ent_rd == {r_prefix, r_byte}) begin
                    n_prefix = r_code;
                    n_state  = S_FIN;
                end else begin
                    n_h     = h_next;
                    n_probe = r_probe + PW'(1);
                    n_state = (r_probe + PW'(1) == H_CNT) ? S_MISS : S_LRD;
                end
            end
            S_MISS: begin
                push.push = 1'b1;
                push.item = '{code_word: r_prefix, final_code: 1'b0};
                if (r_next < limit) begin
                    ent_we  = 1'b1;
                    n_h     = home;
                    n_probe = '0;
                    n_state = S_IRD;
                end else begin
                    n_prefix = {8'd0, r_byte};
                    if (r_rwf) begin
                        n_epoch   = r_epoch + EPOCH_W'(1);
                        n_next    = FIRST_CODE;
                        n_cleared = 1'b1;
                    end
                    n_state = S_FIN;
                end
            end
            S_IRD: begin
                slot_re = 1'b1;
                n_state = S_ICHK;
            end
            S_ICHK: begin
                if (!slot_live) begin
                    slot_we  = 1'b1;
                    slot_wd  = {r_epoch, r_next[CODE_W-1:0]};
                    n_next   = r_next + NEXT_W'(1);
                    n_prefix = {8'd0, r_byte};
                    n_state  = S_FIN;
                end else begin
                    n_h     = h_next;
                    n_probe = r_probe + PW'(1);
                    if (r_probe + PW'(1) == H_CNT) begin
                        // no free slot: entry recorded, pair stays unknown
                        n_next   = r_next + NEXT_W'(1);
                        n_prefix = {8'd0, r_byte};
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_IRD;
                    end
                end
            end
            S_FIN: begin
                if (r_last) begin
                    push.push = 1'b1;
                    push.item = '{code_word: r_prefix, final_code: 1'b1};
                    n_prefix  = '0;
                    n_pvalid  = 1'b0;
                    n_next    = FIRST_CODE;
                    // a clear earlier in this item already emptied the table
                    if (!r_cleared) n_epoch = r_epoch + EPOCH_W'(1);
                end
                n_cleared = 1'b0;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_code_bits <= 5'd16;
            r_rwf       <= 1'b0;
            r_prefix    <= '0;
            r_pvalid    <= 1'b0;
            r_next      <= FIRST_CODE;
            r_epoch     <= '0;
            r_cleared   <= 1'b0;
            r_h         <= '0;
            r_probe     <= '0;
        end else begin
            r_state   <= n_state;
            r_prefix  <= n_prefix;
            r_pvalid  <= n_pvalid;
            r_next    <= n_next;
            r_epoch   <= n_epoch;
            r_cleared <= n_cleared;
            r_h       <= n_h;
            r_probe   <= n_probe;
            if (i_cfg_we && i_cfg_idx == REG_CODE_BITS) r_code_bits <= i_cfg_wdata;
            if (i_cfg_we && i_cfg_idx == REG_RESET_FULL) r_rwf <= i_cfg_wdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_code <= n_code;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("accepted item did not start work");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push |-> (oq_count != 3'd4) || (o_out_valid && i_out_ready))
        else $error("output queue overflow");
    a_last_ends_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_last) |=> !r_pvalid && r_next == FIRST_CODE)
        else $error("stream not closed after last item");
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_epoch == '0) |-> !o_in_ready)
        else $error("item accepted before slot sweep");
endmodule
`default_nettype wire

// ===== dv/tb_lzw_encoder_hashed_dictionary.sv =====
// Testbench: LZW encoder driven with byte streams, codes checked against a behavioral model.
`timescale 1ns / 1ps
module tb_lzw_encoder_hashed_dictionary;
    import lzwe_pkg::*;

    localparam int HASH_N = 131071;
    localparam int DICT_N = 65536;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_data;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [4:0] i_cfg_wdata;

    lzw_encoder_hashed_dictionary dut (.*);

    // model of the dictionary
    logic [16:0]  slots [HASH_N];
    logic [23:0]  entries [DICT_N];
    int unsigned  next_code;
    int unsigned  cur_prefix;
    bit           have_prefix;
    logic [4:0]   width_reg;
    bit           clear_on_full;

    t_in_item  byte_queue[$];
    t_out_item code_queue[$];
    int        errors;
    int        codes_seen;
    bit        no_gaps;
    int        send_gap;
    int        recv_gap;
    int        hold_cnt;
    bit        held_once;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string what, input int unsigned exp_v, input int unsigned got_v);
        $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
        errors++;
    endtask

    function automatic void clear_dict();
        foreach (slots[i]) slots[i] = '0;
        next_code = 256;
    endfunction

    function automatic int unsigned home_slot(int unsigned p, int unsigned b);
        return (p * 257 + b) % HASH_N;
    endfunction

    function automatic int unsigned code_limit();
        int unsigned bits;
        bits = width_reg;
        if (bits < 9) bits = 9;
        if (bits > 16) bits = 16;
        return 1 << bits;
    endfunction

    // returns code+1 on a hit, 0 on a miss
    function automatic int unsigned find_pair(int unsigned p, int unsigned b);
        int unsigned h;
        h = home_slot(p, b);
        for (int n = 0; n < HASH_N; n++) begin
            if (!slots[h][16]) return 0;
            if (entries[slots[h][15:0]] == {p[15:0], b[7:0]}) return slots[h][15:0] + 1;
            h = (h + 1 >= HASH_N) ? 0 : h + 1;
        end
        return 0;
    endfunction

    function automatic void add_pair(int unsigned p, int unsigned b, int unsigned code);
        int unsigned h;
        h = home_slot(p, b);
        entries[code] = {p[15:0], b[7:0]};
        for (int n = 0; n < HASH_N; n++) begin
            if (!slots[h][16]) begin
                slots[h] = {1'b1, code[15:0]};
                return;
            end
            h = (h + 1 >= HASH_N) ? 0 : h + 1;
        end
    endfunction

    function automatic void encode_byte(t_in_item it);
        int unsigned b;
        int unsigned hit;
        b = it.data_byte;
        if (!have_prefix) begin
            cur_prefix = b;
            have_prefix = 1'b1;
        end else begin
            hit = find_pair(cur_prefix, b);
            if (hit != 0) begin
                cur_prefix = hit - 1;
            end else begin
                code_queue.push_back('{code_word: cur_prefix[15:0], final_code: 1'b0});
                if (next_code < code_limit()) begin
                    add_pair(cur_prefix, b, next_code);
                    next_code++;
                end else if (clear_on_full) begin
                    clear_dict();
                end
                cur_prefix = b;
            end
        end
        if (it.end_of_stream) begin
            code_queue.push_back('{code_word: cur_prefix[15:0], final_code: 1'b1});
            clear_dict();
            cur_prefix = 0;
            have_prefix = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the offered item
        end else begin
            if (i_in_valid) encode_byte(i_in_data);
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                i_in_data <= byte_queue.pop_front();
                i_in_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap <= 0;
            hold_cnt <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                codes_seen++;
                if (code_queue.size() == 0) begin
                    report("unexpected code", 0, o_out_data.code_word);
                end else begin
                    if (o_out_data.code_word != code_queue[0].code_word)
                        report("code_word", code_queue[0].code_word, o_out_data.code_word);
                    if (o_out_data.final_code != code_queue[0].final_code)
                        report("final_code", code_queue[0].final_code, o_out_data.final_code);
                    void'(code_queue.pop_front());
                end
            end
            // long hold-off once, so the output queue fills and input stalls
            if (!held_once && codes_seen == 150) begin
                held_once <= 1'b1;
                hold_cnt <= 500;
                i_out_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    task automatic push_byte(input int unsigned b, input bit last);
        byte_queue.push_back('{data_byte: b[7:0], end_of_stream: last});
    endtask

    // mostly a small alphabet so the dictionary grows and hits, with some noise
    task automatic push_stream(input int len, input int alpha, input bit close_it);
        int unsigned base;
        base = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 90)
                push_byte((base + $urandom_range(0, alpha - 1)) & 8'hff,
                          close_it && i == len - 1);
            else
                push_byte($urandom_range(0, 255), close_it && i == len - 1);
        end
    endtask

    task automatic push_streams(input int total);
        int len;
        while (total > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 120);
            if (len > total) len = total;
            push_stream(len, $urandom_range(1, 8), 1'b1);
            total -= len;
        end
    endtask

    task automatic wait_idle();
        while (byte_queue.size() > 0 || i_in_valid || code_queue.size() > 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CODE_BITS) width_reg = val;
        else clear_on_full = val[0];
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [4:0] bits, input bit full_clear);
        write_reg(REG_CODE_BITS, bits);
        write_reg(REG_RESET_FULL, {4'd0, full_clear});
        no_gaps = ~no_gaps;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        errors = 0;
        codes_seen = 0;
        no_gaps = 1'b0;
        held_once = 1'b0;
        foreach (entries[i]) entries[i] = '0;
        clear_dict();
        cur_prefix = 0;
        have_prefix = 1'b0;
        width_reg = 5'd16;
        clear_on_full = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single-byte streams, miss on final byte, hits, byte extremes
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        for (int i = 0; i < 8; i++) push_byte(8'h00, i == 7);
        for (int i = 0; i < 6; i++) push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);
        wait_idle();

        set_config(5'd16, 1'b0);
        push_streams(300);
        wait_idle();

        // smallest dictionary, cleared when full
        set_config(5'd9, 1'b1);
        push_stream(700, 4, 1'b1);
        wait_idle();

        // grow the dictionary with the 16-bit width, then lower the limit mid-stream
        set_config(5'd16, 1'b1);
        push_stream(400, 3, 1'b0);
        wait_idle();
        set_config(5'd9, 1'b0);
        push_stream(200, 3, 1'b1);
        wait_idle();

        // out-of-range widths
        set_config(5'd31, 1'b1);
        push_streams(150);
        wait_idle();
        set_config(5'd0, 1'b1);
        push_streams(150);
        wait_idle();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
